// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the timer table RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// ante holds now -> cons holds in the same cycle
`define ASSERT_IMPLIES(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// ante holds now -> cons holds in the next cycle
`define ASSERT_NEXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/ptt_pkg.sv =====
// ---------------------------------------------------------------------------
// ptt_pkg
// Types and constants shared by the periodic task timer table modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ptt_pkg;

  localparam int SLOTS_DEF     = 16;
  localparam int TIME_BITS_DEF = 48;

  localparam int KIND_W   = 3;
  localparam int SLOT_W   = 4;
  localparam int MS_W     = 32;
  localparam int REP_W    = 16;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  localparam logic [MS_W-1:0] MS_MAX         = '1;
  localparam logic [MS_W-1:0] MAX_WAIT_RESET = 32'd5000;

  // register index, taken from paddr above the byte lanes
  localparam logic REG_MAX_WAIT = 1'b0;

  localparam logic [KIND_W-1:0] K_TICK      = 3'd0;
  localparam logic [KIND_W-1:0] K_SCHEDULE  = 3'd1;
  localparam logic [KIND_W-1:0] K_CANCEL    = 3'd2;
  localparam logic [KIND_W-1:0] K_DELAY_ALL = 3'd3;
  localparam logic [KIND_W-1:0] K_CLEAR     = 3'd4;

  typedef struct packed {
    logic load;
    logic scan_rd;
    logic exec;
    logic fin;
  } dp_cmd_t;

endpackage

// ===== hdl/ptt_apb.sv =====
// ---------------------------------------------------------------------------
// ptt_apb
// Configuration port holding the wait cap register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptt_apb (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ptt_pkg::PADDR_W-1:0]  paddr,
  input  logic [ptt_pkg::PDATA_W-1:0]  pwdata,
  output logic [ptt_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output logic [ptt_pkg::MS_W-1:0]     max_wait_ms
);
  import ptt_pkg::*;

  logic wr_hit;

  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite && (paddr[PADDR_W-1] == REG_MAX_WAIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_wait_ms <= MAX_WAIT_RESET;
    end else if (wr_hit) begin
      max_wait_ms <= pwdata;
    end
  end

  always_comb begin
    if (paddr[PADDR_W-1] == REG_MAX_WAIT) begin
      prdata = max_wait_ms;
    end else begin
      prdata = '0;
    end
  end

endmodule

// ===== hdl/ptt_ctrl.sv =====
// ---------------------------------------------------------------------------
// ptt_ctrl
// Sequencer: accepts items, sweeps the slot table and orders the results.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ptt_ctrl #(
  parameter  int SLOTS = ptt_pkg::SLOTS_DEF,
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [ptt_pkg::KIND_W-1:0]  kind,
  output logic                        busy,
  output ptt_pkg::dp_cmd_t            cmd,
  output logic [IDX_W-1:0]            rd_addr
);
  import ptt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN1,
    S_DRAIN2,
    S_FIN,
    S_EXEC
  } state_t;

  state_t           state;
  logic [IDX_W-1:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      cnt   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            busy <= 1'b1;
            cnt  <= '0;
            if (kind == K_TICK || kind == K_DELAY_ALL) begin
              state <= S_SCAN;
            end else begin
              state <= S_EXEC;
            end
          end
        end
        S_SCAN: begin
          if (cnt == IDX_W'(SLOTS - 1)) begin
            state <= S_DRAIN1;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_DRAIN1: state <= S_DRAIN2;
        S_DRAIN2: state <= S_FIN;
        S_FIN: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
        S_EXEC: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
        default: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    cmd.load    = start && !busy;
    cmd.scan_rd = (state == S_SCAN);
    cmd.exec    = (state == S_EXEC);
    cmd.fin     = (state == S_FIN);
    rd_addr     = cnt;
  end

  `ASSERT_IMPLIES(a_busy_state, clk, rst, 1'b1, busy == (state != S_IDLE), "busy out of step")
  `ASSERT_NEXT(a_sweep_start, clk, rst, start && !busy && (kind == K_TICK || kind == K_DELAY_ALL), state == S_SCAN && cnt == '0, "sweep did not start at slot zero")
  `ASSERT_NEXT(a_sweep_end, clk, rst, state == S_SCAN && cnt == IDX_W'(SLOTS - 1), state == S_DRAIN1, "sweep overran")

endmodule

// ===== hdl/ptt_datapath.sv =====
// ---------------------------------------------------------------------------
// ptt_datapath
// Slot store, due-time arithmetic, wait tracking and the result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ptt_datapath #(
  parameter  int SLOTS     = ptt_pkg::SLOTS_DEF,
  parameter  int TIME_BITS = ptt_pkg::TIME_BITS_DEF,
  localparam int IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  ptt_pkg::dp_cmd_t            cmd,
  input  logic [IDX_W-1:0]            rd_addr,
  input  logic [ptt_pkg::KIND_W-1:0]  kind,
  input  logic [TIME_BITS-1:0]        now_ms,
  input  logic [ptt_pkg::SLOT_W-1:0]  slot,
  input  logic [ptt_pkg::MS_W-1:0]    delay_ms,
  input  logic [ptt_pkg::MS_W-1:0]    interval_ms,
  input  logic [ptt_pkg::REP_W-1:0]   repeat_count,
  input  logic                        repeat_forever,
  input  logic [ptt_pkg::MS_W-1:0]    max_wait_ms,
  output logic                        strobe,
  output logic                        fired,
  output logic [ptt_pkg::SLOT_W-1:0]  fired_slot,
  output logic [ptt_pkg::MS_W-1:0]    wait_ms,
  output logic                        status,
  output logic                        last
);
  import ptt_pkg::*;

  localparam int WIDE_W = IDX_W + SLOT_W;

  // latched item
  logic [KIND_W-1:0]    kind_r;
  logic [TIME_BITS-1:0] now_r;
  logic [SLOT_W-1:0]    slot_r;
  logic [MS_W-1:0]      dly_r;
  logic [MS_W-1:0]      ivl_r;
  logic [REP_W-1:0]     rep_r;
  logic                 fvr_r;

  // slot store
  logic [TIME_BITS-1:0] due_mem    [SLOTS];
  logic [MS_W-1:0]      period_mem [SLOTS];
  logic [REP_W-1:0]     reps_mem   [SLOTS];
  logic                 fvr_mem    [SLOTS];
  logic [SLOTS-1:0]     slot_valid;

  logic [TIME_BITS-1:0] due_q;
  logic [MS_W-1:0]      period_q;
  logic [REP_W-1:0]     reps_q;
  logic                 fvr_q;

  logic                 a_vld;
  logic [IDX_W-1:0]     a_idx;
  logic                 b_vld;
  logic [MS_W-1:0]      b_cand;
  logic [MS_W-1:0]      wait_acc;

  logic                 is_tick;
  logic                 is_delay;
  logic                 is_sched;
  logic [WIDE_W-1:0]    slot_wide;
  logic [IDX_W-1:0]     slot_idx;
  logic                 slot_in_range;
  logic                 sched_busy;
  logic [WIDE_W-1:0]    a_idx_wide;
  logic                 a_live;
  logic                 due_later;
  logic [TIME_BITS-1:0] due_gap;
  logic [MS_W-1:0]      gap_sat;
  logic [TIME_BITS-1:0] add_a;
  logic [MS_W-1:0]      add_b;
  logic [TIME_BITS:0]   add_sum;
  logic [TIME_BITS-1:0] sat_sum;
  logic                 retire;
  logic                 fire;
  logic                 cand_vld;
  logic [MS_W-1:0]      cand;

  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  logic [TIME_BITS-1:0] wr_due;
  logic [MS_W-1:0]      wr_period;
  logic [REP_W-1:0]     wr_reps;
  logic                 wr_fvr;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= kind;
      now_r  <= now_ms;
      slot_r <= slot;
      dly_r  <= delay_ms;
      ivl_r  <= interval_ms;
      rep_r  <= repeat_count;
      fvr_r  <= repeat_forever;
    end
  end

  always_comb begin
    is_tick       = (kind_r == K_TICK);
    is_delay      = (kind_r == K_DELAY_ALL);
    is_sched      = (kind_r == K_SCHEDULE);
    slot_wide     = {IDX_W'(0), slot_r};
    slot_idx      = slot_wide[IDX_W-1:0];
    slot_in_range = (slot_wide < WIDE_W'(SLOTS));
    sched_busy    = slot_in_range && slot_valid[slot_idx];
    a_idx_wide    = {SLOT_W'(0), a_idx};
    a_live        = a_vld && slot_valid[a_idx];

    due_later = (due_q > now_r);
    due_gap   = due_q - now_r;
    gap_sat   = (due_gap > TIME_BITS'(MS_MAX)) ? MS_MAX : due_gap[MS_W-1:0];

    // saturating add shared by tick, schedule and delay all
    add_a   = is_delay ? due_q : now_r;
    add_b   = is_tick ? period_q : dly_r;
    add_sum = {1'b0, add_a} + (TIME_BITS + 1)'(add_b);
    sat_sum = add_sum[TIME_BITS] ? '1 : add_sum[TIME_BITS-1:0];

    retire   = !fvr_q && (reps_q == '0);
    fire     = a_live && is_tick && !due_later;
    cand_vld = a_live && is_tick && (due_later || !retire);
    cand     = due_later ? gap_sat : period_q;
  end

  always_comb begin
    wr_en     = 1'b0;
    wr_addr   = a_idx;
    wr_due    = sat_sum;
    wr_period = period_q;
    wr_reps   = reps_q;
    wr_fvr    = fvr_q;
    if (a_live && is_delay) begin
      wr_en = 1'b1;
    end
    if (fire && !retire) begin
      wr_en = 1'b1;
      if (!fvr_q) begin
        wr_reps = reps_q - REP_W'(1);
      end
    end
    if (cmd.exec && is_sched && slot_in_range && !slot_valid[slot_idx]) begin
      wr_en     = 1'b1;
      wr_addr   = slot_idx;
      wr_period = ivl_r;
      wr_reps   = rep_r;
      wr_fvr    = fvr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      due_mem[wr_addr]    <= wr_due;
      period_mem[wr_addr] <= wr_period;
      reps_mem[wr_addr]   <= wr_reps;
      fvr_mem[wr_addr]    <= wr_fvr;
    end
    if (cmd.scan_rd) begin
      due_q    <= due_mem[rd_addr];
      period_q <= period_mem[rd_addr];
      reps_q   <= reps_mem[rd_addr];
      fvr_q    <= fvr_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else begin
      if (fire && retire) begin
        slot_valid[a_idx] <= 1'b0;
      end
      if (cmd.exec) begin
        unique case (kind_r)
          K_SCHEDULE: begin
            if (slot_in_range) begin
              slot_valid[slot_idx] <= 1'b1;
            end
          end
          K_CANCEL: begin
            if (slot_in_range) begin
              slot_valid[slot_idx] <= 1'b0;
            end
          end
          K_CLEAR: slot_valid <= '0;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld  <= 1'b0;
      b_vld  <= 1'b0;
      strobe <= 1'b0;
    end else begin
      a_vld  <= cmd.scan_rd;
      b_vld  <= cand_vld;
      strobe <= fire || cmd.exec || cmd.fin;
    end
  end

  always_ff @(posedge clk) begin
    a_idx  <= rd_addr;
    b_cand <= cand;
    if (cmd.load) begin
      wait_acc <= max_wait_ms;
    end else if (b_vld && (b_cand < wait_acc)) begin
      wait_acc <= b_cand;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      fired      <= 1'b1;
      fired_slot <= a_idx_wide[SLOT_W-1:0];
      wait_ms    <= '0;
      status     <= 1'b0;
      last       <= 1'b0;
    end else begin
      fired      <= 1'b0;
      fired_slot <= '0;
      wait_ms    <= (cmd.fin && is_tick) ? wait_acc : '0;
      status     <= cmd.exec && is_sched && sched_busy;
      last       <= 1'b1;
    end
  end

  `ASSERT_IMPLIES(a_fin_drained, clk, rst, cmd.fin, !a_vld && !b_vld, "final item before sweep drained")
  `ASSERT_IMPLIES(a_exec_quiet, clk, rst, cmd.exec, !a_vld && !b_vld && !fire, "command during sweep")
  `ASSERT_NEXT(a_retire_clears, clk, rst, fire && retire, !slot_valid[$past(a_idx)], "retired slot still valid")

endmodule

// ===== hdl/periodic_task_timer_table.sv =====
// ---------------------------------------------------------------------------
// periodic_task_timer_table
// Table of periodic timer slots driven by tick, schedule, cancel, delay-all
// and clear items.
// ---------------------------------------------------------------------------
// Usage:
//   Item channel: present kind, now_ms and the other fields with start high;
//   the item is taken at a rising edge with start high and busy low.
//   Result channel: each result sits on fired, fired_slot, wait_ms, status
//   and last for one cycle with strobe high; the receiver cannot stall it.
//   Tick and delay-all sweep the slot store one slot a cycle through its
//   single read port, then drain a three-stage pipe: busy stays high
//   through the sweep, the drain states and S_FIN, so the next item is
//   taken only after busy falls. Fire results come out in slot order,
//   and the final result with last high is registered from S_FIN, once
//   the pipe has drained.
//   Schedule, cancel, clear and unused kinds: one result on the ports from
//   the edge after the accept edge, busy for one cycle.
//   APB port: max_wait_ms at byte address 0; the user must write it only while idle, which the block does not enforce.
//   Reset: clears all slots and the controller, max_wait_ms returns to 5000.
//   Slot contents are not cleared; the sweep reads every slot but acts only on valid ones.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module periodic_task_timer_table #(
  parameter int SLOTS     = ptt_pkg::SLOTS_DEF,
  parameter int TIME_BITS = ptt_pkg::TIME_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [ptt_pkg::KIND_W-1:0]  kind,
  input  logic [TIME_BITS-1:0]        now_ms,
  input  logic [ptt_pkg::SLOT_W-1:0]  slot,
  input  logic [ptt_pkg::MS_W-1:0]    delay_ms,
  input  logic [ptt_pkg::MS_W-1:0]    interval_ms,
  input  logic [ptt_pkg::REP_W-1:0]   repeat_count,
  input  logic                        repeat_forever,
  output logic                        strobe,
  output logic                        fired,
  output logic [ptt_pkg::SLOT_W-1:0]  fired_slot,
  output logic [ptt_pkg::MS_W-1:0]    wait_ms,
  output logic                        status,
  output logic                        last,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ptt_pkg::PADDR_W-1:0] paddr,
  input  logic [ptt_pkg::PDATA_W-1:0] pwdata,
  output logic [ptt_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import ptt_pkg::*;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  dp_cmd_t          cmd;
  logic [IDX_W-1:0] rd_addr;
  logic [MS_W-1:0]  max_wait_ms;

  ptt_apb u_apb (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .max_wait_ms (max_wait_ms)
  );

  ptt_ctrl #(
    .SLOTS (SLOTS)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .kind    (kind),
    .busy    (busy),
    .cmd     (cmd),
    .rd_addr (rd_addr)
  );

  ptt_datapath #(
    .SLOTS     (SLOTS),
    .TIME_BITS (TIME_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .rd_addr        (rd_addr),
    .kind           (kind),
    .now_ms         (now_ms),
    .slot           (slot),
    .delay_ms       (delay_ms),
    .interval_ms    (interval_ms),
    .repeat_count   (repeat_count),
    .repeat_forever (repeat_forever),
    .max_wait_ms    (max_wait_ms),
    .strobe         (strobe),
    .fired          (fired),
    .fired_slot     (fired_slot),
    .wait_ms        (wait_ms),
    .status         (status),
    .last           (last)
  );

endmodule
